/* rtl/core/fga_pkg.sv */
// Shared types and constants for the filtered group aggregate block.
// No dependencies; imported by the controller, the datapath and the top level.
package fga_pkg;

    // Accumulator and port widths
    localparam int ACC_BITS   = 63;
    localparam int OUT_BITS   = 63;
    localparam int CNT_BITS   = 32;
    localparam int DATE_BITS  = 32;
    localparam int QTY_BITS   = 8;
    localparam int PRICE_BITS = 24;
    localparam int PCT_BITS   = 7;
    localparam int FLAG_BITS  = 2;

    // Product widths: price*(100-disc) and that times (100+tax)
    localparam int DP_BITS = PRICE_BITS + PCT_BITS;
    localparam int CH_BITS = DP_BITS + PCT_BITS + 1;

    // Groups: index is {return_flag, line_status}
    localparam int NUM_GROUPS = 6;
    localparam int GRP_BITS   = 3;
    localparam logic [GRP_BITS-1:0] FIRST_GRP = '0;
    localparam logic [GRP_BITS-1:0] LAST_GRP  = GRP_BITS'(NUM_GROUPS - 1);

    localparam logic [FLAG_BITS-1:0] FLAG_MAX = 2'd2;
    localparam logic [PCT_BITS-1:0]  PCT_MAX  = 7'd100;

    // Request opcodes
    localparam logic OP_ROW  = 1'b0;
    localparam logic OP_DUMP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_DUMP
    } fga_state_t;

    // Controller to datapath
    typedef struct packed {
        logic                capture;
        logic                mul1_en;
        logic                mul2_en;
        logic                acc_en;
        logic                load_out;
        logic [GRP_BITS-1:0] grp;
    } fga_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic row_hit;
        logic out_free;
    } fga_sts_t;

endpackage

/* rtl/core/fga_ctrl.sv */
// Controller for the filtered group aggregate block: sequences row updates
// and the six-group dump. Depends on fga_pkg.
module fga_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              op,
    input  fga_pkg::fga_sts_t sts,
    output fga_pkg::fga_cmd_t cmd
);
    import fga_pkg::*;

    fga_state_t          state_reg, state_next;
    logic [GRP_BITS-1:0] grp_reg, grp_next;

    // State and dump index registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            grp_reg   <= FIRST_GRP;
        end
        else
        begin
            state_reg <= state_next;
            grp_reg   <= grp_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        grp_next     = grp_reg;
        in_stall     = 1'b1;
        cmd          = '0;
        cmd.grp      = grp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (op == OP_DUMP)
                    begin
                        state_next = ST_DUMP;
                        grp_next   = FIRST_GRP;
                    end
                    else
                    begin
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_MUL1:
            begin
                // filtered rows end here
                if (sts.row_hit)
                begin
                    cmd.mul1_en = 1'b1;
                    state_next  = ST_MUL2;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL2:
            begin
                cmd.mul2_en = 1'b1;
                state_next  = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_en = 1'b1;
                state_next = ST_IDLE;
            end
            ST_DUMP:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (grp_reg == LAST_GRP)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        grp_next = grp_reg + GRP_BITS'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/fga_datapath.sv */
// Datapath for the filtered group aggregate block: cutoff register, row
// capture, two multiply stages, group accumulators and the output register.
// Depends on fga_pkg.
module fga_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fga_pkg::fga_cmd_t              cmd,
    output fga_pkg::fga_sts_t              sts,
    // configuration
    input  logic                           cfg_valid,
    input  logic [fga_pkg::DATE_BITS-1:0]  cfg_data,
    // row fields
    input  logic [fga_pkg::DATE_BITS-1:0]  ship_date,
    input  logic [fga_pkg::FLAG_BITS-1:0]  return_flag,
    input  logic                           line_status,
    input  logic [fga_pkg::QTY_BITS-1:0]   quantity,
    input  logic [fga_pkg::PRICE_BITS-1:0] price_cents,
    input  logic [fga_pkg::PCT_BITS-1:0]   discount_pct,
    input  logic [fga_pkg::PCT_BITS-1:0]   tax_pct,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [fga_pkg::FLAG_BITS-1:0]  out_return_flag,
    output logic                           out_line_status,
    output logic [fga_pkg::CNT_BITS-1:0]   row_count,
    output logic [fga_pkg::OUT_BITS-1:0]   sum_quantity,
    output logic [fga_pkg::OUT_BITS-1:0]   sum_price,
    output logic [fga_pkg::OUT_BITS-1:0]   sum_disc_price,
    output logic [fga_pkg::OUT_BITS-1:0]   sum_charge,
    output logic [fga_pkg::OUT_BITS-1:0]   sum_discount,
    output logic                           last_group
);
    import fga_pkg::*;

    localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

    // saturating add, result never exceeds ACC_MAX
    function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] a,
                                                    input logic [ACC_BITS-1:0] b);
        logic [ACC_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, ACC_MAX})
            return ACC_MAX;
        return s[ACC_BITS-1:0];
    endfunction

    logic [DATE_BITS-1:0]  cutoff_reg;
    logic                  hit_reg;
    logic [GRP_BITS-1:0]   row_grp_reg;
    logic [QTY_BITS-1:0]   qty_reg;
    logic [PRICE_BITS-1:0] price_reg;
    logic [PCT_BITS-1:0]   disc_reg;
    logic [PCT_BITS-1:0]   tax_reg;
    logic [DP_BITS-1:0]    dp_reg;
    logic [CH_BITS-1:0]    ch_reg;

    logic [CNT_BITS-1:0] cnt_reg   [NUM_GROUPS];
    logic [ACC_BITS-1:0] qsum_reg  [NUM_GROUPS];
    logic [ACC_BITS-1:0] psum_reg  [NUM_GROUPS];
    logic [ACC_BITS-1:0] dpsum_reg [NUM_GROUPS];
    logic [ACC_BITS-1:0] chsum_reg [NUM_GROUPS];
    logic [ACC_BITS-1:0] dsum_reg  [NUM_GROUPS];

    logic                out_valid_reg;
    logic [GRP_BITS-1:0] out_grp_reg;
    logic [CNT_BITS-1:0] out_cnt_reg;
    logic [ACC_BITS-1:0] out_q_reg, out_p_reg, out_dp_reg, out_ch_reg, out_d_reg;

    logic                  row_hit;
    logic [PCT_BITS-1:0]   disc_clamp, tax_clamp;
    logic [GRP_BITS-1:0]   rd_addr;
    logic [CNT_BITS-1:0]   cnt_next;
    logic [ACC_BITS-1:0]   qsum_next, psum_next, dpsum_next, chsum_next, dsum_next;

    // Cutoff register, always ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cutoff_reg <= '0;
        else if (cfg_valid)
            cutoff_reg <= cfg_data;
    end

    // Row filter and clamping at capture
    assign row_hit    = (ship_date <= cutoff_reg) && (return_flag <= FLAG_MAX);
    assign disc_clamp = (discount_pct > PCT_MAX) ? PCT_MAX : discount_pct;
    assign tax_clamp  = (tax_pct > PCT_MAX) ? PCT_MAX : tax_pct;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else if (cmd.capture)
            hit_reg <= row_hit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_grp_reg <= {return_flag, line_status};
            qty_reg     <= quantity;
            price_reg   <= price_cents;
            disc_reg    <= disc_clamp;
            tax_reg     <= tax_clamp;
        end
    end

    // Multiply stages: discounted price, then charge
    always_ff @(posedge clk)
    begin
        if (cmd.mul1_en)
            dp_reg <= DP_BITS'(price_reg) * DP_BITS'(PCT_MAX - disc_reg);
        if (cmd.mul2_en)
            ch_reg <= CH_BITS'(dp_reg) * CH_BITS'({1'b0, PCT_MAX} + {1'b0, tax_reg});
    end

    // One shared read port: dump index while loading, else the row group
    assign rd_addr = cmd.load_out ? cmd.grp : row_grp_reg;

    always_comb
    begin
        cnt_next   = (cnt_reg[rd_addr] == CNT_MAX) ? CNT_MAX
                                                   : cnt_reg[rd_addr] + CNT_BITS'(1);
        qsum_next  = sat_add(qsum_reg[rd_addr],  ACC_BITS'(qty_reg));
        psum_next  = sat_add(psum_reg[rd_addr],  ACC_BITS'(price_reg));
        dpsum_next = sat_add(dpsum_reg[rd_addr], ACC_BITS'(dp_reg));
        chsum_next = sat_add(chsum_reg[rd_addr], ACC_BITS'(ch_reg));
        dsum_next  = sat_add(dsum_reg[rd_addr],  ACC_BITS'(disc_reg));
    end

    // Group accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                cnt_reg[g]   <= '0;
                qsum_reg[g]  <= '0;
                psum_reg[g]  <= '0;
                dpsum_reg[g] <= '0;
                chsum_reg[g] <= '0;
                dsum_reg[g]  <= '0;
            end
        end
        else if (cmd.acc_en)
        begin
            cnt_reg[rd_addr]   <= cnt_next;
            qsum_reg[rd_addr]  <= qsum_next;
            psum_reg[rd_addr]  <= psum_next;
            dpsum_reg[rd_addr] <= dpsum_next;
            chsum_reg[rd_addr] <= chsum_next;
            dsum_reg[rd_addr]  <= dsum_next;
        end
    end

    // Output register
    assign sts.out_free = !out_valid_reg || !out_stall;
    assign sts.row_hit  = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_grp_reg <= cmd.grp;
            out_cnt_reg <= cnt_reg[rd_addr];
            out_q_reg   <= qsum_reg[rd_addr];
            out_p_reg   <= psum_reg[rd_addr];
            out_dp_reg  <= dpsum_reg[rd_addr];
            out_ch_reg  <= chsum_reg[rd_addr];
            out_d_reg   <= dsum_reg[rd_addr];
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_return_flag = out_grp_reg[GRP_BITS-1:1];
    assign out_line_status = out_grp_reg[0];
    assign row_count       = out_cnt_reg;
    assign sum_quantity    = OUT_BITS'(out_q_reg);
    assign sum_price       = OUT_BITS'(out_p_reg);
    assign sum_disc_price  = OUT_BITS'(out_dp_reg);
    assign sum_charge      = OUT_BITS'(out_ch_reg);
    assign sum_discount    = OUT_BITS'(out_d_reg);
    assign last_group      = (out_grp_reg == LAST_GRP);

endmodule

/* rtl/core/filtered_group_aggregate.sv */
// Row request: accepted in ST_IDLE, then two multiply stages (ST_MUL1, ST_MUL2)
// and the accumulator write (ST_ACC); a row above the cutoff or with flag code 3
// ends in ST_MUL1. Dump request: six results, loaded from ST_DUMP after accept, one
// per cycle while the output is not stalled; input reopens once the last is loaded.
// One request at a time; the shared accumulator port and the FSM set the rate.
// Reset (rst_n, async) clears the cutoff, all group accumulators and the FSM at once.
module filtered_group_aggregate (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           op,
    input  logic [fga_pkg::DATE_BITS-1:0]  ship_date,
    input  logic [fga_pkg::FLAG_BITS-1:0]  return_flag,
    input  logic                           line_status,
    input  logic [fga_pkg::QTY_BITS-1:0]   quantity,
    input  logic [fga_pkg::PRICE_BITS-1:0] price_cents,
    input  logic [fga_pkg::PCT_BITS-1:0]   discount_pct,
    input  logic [fga_pkg::PCT_BITS-1:0]   tax_pct,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [fga_pkg::FLAG_BITS-1:0]  out_return_flag,
    output logic                           out_line_status,
    output logic [fga_pkg::CNT_BITS-1:0]   row_count,
    output logic [fga_pkg::OUT_BITS-1:0]   sum_quantity,
    output logic [fga_pkg::OUT_BITS-1:0]   sum_price,
    output logic [fga_pkg::OUT_BITS-1:0]   sum_disc_price,
    output logic [fga_pkg::OUT_BITS-1:0]   sum_charge,
    output logic [fga_pkg::OUT_BITS-1:0]   sum_discount,
    output logic                           last_group,
    // configuration write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fga_pkg::DATE_BITS-1:0]  cfg_data
);
    import fga_pkg::*;

    fga_cmd_t cmd;
    fga_sts_t sts;

    assign cfg_ready = 1'b1;

    fga_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .sts      (sts),
        .cmd      (cmd)
    );

    fga_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .ship_date       (ship_date),
        .return_flag     (return_flag),
        .line_status     (line_status),
        .quantity        (quantity),
        .price_cents     (price_cents),
        .discount_pct    (discount_pct),
        .tax_pct         (tax_pct),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_return_flag (out_return_flag),
        .out_line_status (out_line_status),
        .row_count       (row_count),
        .sum_quantity    (sum_quantity),
        .sum_price       (sum_price),
        .sum_disc_price  (sum_disc_price),
        .sum_charge      (sum_charge),
        .sum_discount    (sum_discount),
        .last_group      (last_group)
    );

endmodule
